/* hdl/ttb_pkg.sv */
// ----------------------------------------------------------------------------
// Triangle tangent basis package
// Shared widths and the job record that passes from the front to the back.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int POS_W   = 24;  // Q12.12 position
    localparam int TEX_W   = 18;  // Q4.14 texture coordinate
    localparam int EDGE_W  = POS_W + 1;
    localparam int TDEL_W  = TEX_W + 1;
    localparam int PROD_W  = EDGE_W + TDEL_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int DET_W   = 2 * TDEL_W + 1;
    localparam int RES_W   = 32;
    localparam int FIFO_DEPTH = 2;
    localparam int Q_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Back end sizes: six output components, the numerator magnitude and the
    // overflow compare against the divisor scaled by 2^14.
    localparam int NUM_RES = 6;
    localparam int UN_W    = ACC_W;
    localparam int CMP_W   = DET_W + 14;

    typedef struct packed {
        logic signed [EDGE_W-1:0] x1;
        logic signed [EDGE_W-1:0] y1;
        logic signed [EDGE_W-1:0] z1;
        logic signed [EDGE_W-1:0] x2;
        logic signed [EDGE_W-1:0] y2;
        logic signed [EDGE_W-1:0] z2;
        logic signed [TDEL_W-1:0] s1;
        logic signed [TDEL_W-1:0] t1;
        logic signed [TDEL_W-1:0] s2;
        logic signed [TDEL_W-1:0] t2;
    } t_job;

    // Queue status seen by the producer and the consumer.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* hdl/triangle_tangent_basis.sv */
// ----------------------------------------------------------------------------
// Triangle tangent basis
// Per-triangle s and t tangent directions from three vertex transfers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  vertex    in         i_valid / o_stall    i_pos_x/y/z, i_tex_u/v
//  tangent   out        o_valid / i_stall    o_tan_s_x/y/z, o_tan_t_x/y/z,
//                                            o_degenerate
//
// Vertex transfers are taken one per cycle, unless o_stall holds them, into
// the front end; the first two of each triangle are held and the third forms
// the deltas and enters a two-entry job queue. The back end works one job at a
// time on a single 25x19 multiplier and a one-bit-per-cycle restoring divider:
// two products and a difference give the determinant, and each of the six
// outputs takes two products, a difference, an overflow check, the division
// and saturation. A zero determinant ends the job and gives a degenerate result.
// Reset is synchronous and active low; it clears the vertex count, the queue
// and the sequencer. A stall on the result side holds the output register and
// lets the queue fill before the vertex side stalls.
// ----------------------------------------------------------------------------
module triangle_tangent_basis (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [ttb_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [ttb_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [ttb_pkg::POS_W-1:0]  i_pos_z,
    input  logic signed [ttb_pkg::TEX_W-1:0]  i_tex_u,
    input  logic signed [ttb_pkg::TEX_W-1:0]  i_tex_v,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [ttb_pkg::RES_W-1:0]  o_tan_s_x,
    output logic signed [ttb_pkg::RES_W-1:0]  o_tan_s_y,
    output logic signed [ttb_pkg::RES_W-1:0]  o_tan_s_z,
    output logic signed [ttb_pkg::RES_W-1:0]  o_tan_t_x,
    output logic signed [ttb_pkg::RES_W-1:0]  o_tan_t_y,
    output logic signed [ttb_pkg::RES_W-1:0]  o_tan_t_z,
    output logic                              o_degenerate
);
    import ttb_pkg::*;

    t_job      w_push_job;
    t_job      w_pop_job;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;

    // Front end: counts vertices and builds the triangle's deltas.
    ttb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_tex_u    (i_tex_u),
        .i_tex_v    (i_tex_v),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // The queue lets the front keep taking vertices while the back divides.
    ttb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_pop_job),
        .o_status (w_q_status)
    );

    // Back end: determinant, six numerators and six saturated quotients.
    ttb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (w_q_status),
        .i_job        (w_pop_job),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tan_s_x    (o_tan_s_x),
        .o_tan_s_y    (o_tan_s_y),
        .o_tan_s_z    (o_tan_s_z),
        .o_tan_t_x    (o_tan_t_x),
        .o_tan_t_y    (o_tan_t_y),
        .o_tan_t_z    (o_tan_t_z),
        .o_degenerate (o_degenerate)
    );

endmodule

/* hdl/ttb_front.sv */
// ----------------------------------------------------------------------------
// Triangle tangent basis front end
// Collects three vertices and forms the edge and texture deltas of a triangle.
// ----------------------------------------------------------------------------
module ttb_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [ttb_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [ttb_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [ttb_pkg::POS_W-1:0] i_pos_z,
    input  logic signed [ttb_pkg::TEX_W-1:0] i_tex_u,
    input  logic signed [ttb_pkg::TEX_W-1:0] i_tex_v,
    input  ttb_pkg::t_q_status             i_q_status,
    output logic                           o_push,
    output ttb_pkg::t_job                  o_job
);
    import ttb_pkg::*;

    logic [1:0]              r_cnt;
    logic [1:0]              n_cnt;
    logic signed [POS_W-1:0] r_hx [2];
    logic signed [POS_W-1:0] r_hy [2];
    logic signed [POS_W-1:0] r_hz [2];
    logic signed [TEX_W-1:0] r_hu [2];
    logic signed [TEX_W-1:0] r_hv [2];
    logic                    w_accept;
    logic                    w_third;
    logic                    w_slot;

    // The third vertex can only be taken when the queue has room for the job.
    assign w_third  = (r_cnt == 2'd2);
    assign o_stall  = w_third && i_q_status.full;
    assign w_accept = i_valid && !o_stall;
    assign o_push   = w_accept && w_third;
    assign w_slot   = (r_cnt == 2'd1);

    always_comb begin
        n_cnt = r_cnt;
        if (w_accept) begin
            case (r_cnt)
                2'd0:    n_cnt = 2'd1;
                2'd1:    n_cnt = 2'd2;
                2'd2:    n_cnt = 2'd0;
                default: n_cnt = 2'd1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_third) begin
            r_hx[w_slot] <= i_pos_x;
            r_hy[w_slot] <= i_pos_y;
            r_hz[w_slot] <= i_pos_z;
            r_hu[w_slot] <= i_tex_u;
            r_hv[w_slot] <= i_tex_v;
        end
    end

    always_comb begin
        o_job.x1 = EDGE_W'(r_hx[1]) - EDGE_W'(r_hx[0]);
        o_job.y1 = EDGE_W'(r_hy[1]) - EDGE_W'(r_hy[0]);
        o_job.z1 = EDGE_W'(r_hz[1]) - EDGE_W'(r_hz[0]);
        o_job.x2 = EDGE_W'(i_pos_x) - EDGE_W'(r_hx[0]);
        o_job.y2 = EDGE_W'(i_pos_y) - EDGE_W'(r_hy[0]);
        o_job.z2 = EDGE_W'(i_pos_z) - EDGE_W'(r_hz[0]);
        o_job.s1 = TDEL_W'(r_hu[1]) - TDEL_W'(r_hu[0]);
        o_job.t1 = TDEL_W'(r_hv[1]) - TDEL_W'(r_hv[0]);
        o_job.s2 = TDEL_W'(i_tex_u) - TDEL_W'(r_hu[0]);
        o_job.t2 = TDEL_W'(i_tex_v) - TDEL_W'(r_hv[0]);
    end

endmodule

/* hdl/ttb_queue.sv */
// ----------------------------------------------------------------------------
// Triangle tangent basis job queue
// A two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ttb_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ttb_pkg::t_job       i_job,
    input  logic                i_pop,
    output ttb_pkg::t_job       o_job,
    output ttb_pkg::t_q_status  o_status
);
    import ttb_pkg::*;

    t_job               r_mem [FIFO_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_count;

    assign o_status.full  = (r_count == Q_CNT_W'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_job          = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wp + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == Q_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rp + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/ttb_back.sv */
// ----------------------------------------------------------------------------
// Triangle tangent basis back end
// Shared multiplier and bit-serial divider that turn a job into tangents.
// ----------------------------------------------------------------------------
module ttb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ttb_pkg::t_q_status            i_q_status,
    input  ttb_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [ttb_pkg::RES_W-1:0] o_tan_s_x,
    output logic signed [ttb_pkg::RES_W-1:0] o_tan_s_y,
    output logic signed [ttb_pkg::RES_W-1:0] o_tan_s_z,
    output logic signed [ttb_pkg::RES_W-1:0] o_tan_t_x,
    output logic signed [ttb_pkg::RES_W-1:0] o_tan_t_y,
    output logic signed [ttb_pkg::RES_W-1:0] o_tan_t_z,
    output logic                          o_degenerate
);
    import ttb_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_SUB  = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_SAT  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                   r_state;
    t_job                     r_job;
    logic                     r_half;
    logic [2:0]               r_oi;      // 0 is the determinant, 1..6 the outputs
    logic signed [PROD_W-1:0] r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [DET_W-1:0]  r_det;
    logic [DET_W-1:0]         r_dmag;
    logic [UN_W-1:0]          r_un;
    logic                     r_neg;
    logic                     r_ovf;
    logic [DET_W-1:0]         r_rem;
    logic [RES_W-1:0]         r_dlo;
    logic [RES_W-1:0]         r_q;
    logic [4:0]               r_bit;
    logic [RES_W-1:0]         r_res [NUM_RES];
    logic                     r_deg;
    logic                     r_ovalid;
    logic [RES_W-1:0]         r_out [NUM_RES];
    logic                     r_odeg;

    logic signed [EDGE_W-1:0] w_ma;
    logic signed [TDEL_W-1:0] w_mb;
    logic signed [EDGE_W-1:0] w_e1;
    logic signed [EDGE_W-1:0] w_e2;
    logic signed [ACC_W-1:0]  w_acc;
    logic [DET_W:0]           w_r2;
    logic                     w_ge;
    logic [RES_W-1:0]         w_sat;
    logic                     w_out_free;
    logic [2:0]               w_ridx;

    // Edge components for the axis of the current output.
    always_comb begin
        case (r_oi)
            3'd1, 3'd4: begin
                w_e1 = r_job.x1;
                w_e2 = r_job.x2;
            end
            3'd2, 3'd5: begin
                w_e1 = r_job.y1;
                w_e2 = r_job.y2;
            end
            default: begin
                w_e1 = r_job.z1;
                w_e2 = r_job.z2;
            end
        endcase
    end

    // Operand selection: the first product minus the second gives each term.
    always_comb begin
        if (r_oi == 3'd0) begin
            w_ma = r_half ? EDGE_W'(r_job.s2) : EDGE_W'(r_job.s1);
            w_mb = r_half ? r_job.t1 : r_job.t2;
        end else if (r_oi <= 3'd3) begin
            w_ma = r_half ? w_e2 : w_e1;
            w_mb = r_half ? r_job.t1 : r_job.t2;
        end else begin
            w_ma = r_half ? w_e1 : w_e2;
            w_mb = r_half ? r_job.s2 : r_job.s1;
        end
    end

    assign w_acc = ACC_W'(r_p0) - ACC_W'(r_p1);
    assign w_r2  = {r_rem, r_dlo[RES_W-1]};
    assign w_ge  = (w_r2 >= {1'b0, r_dmag});
    assign w_ridx = r_oi - 3'd1;

    // Saturate the magnitude and apply the sign.
    always_comb begin
        if (!r_neg) begin
            w_sat = (r_ovf || r_q[RES_W-1]) ? {1'b0, {(RES_W-1){1'b1}}} : r_q;
        end else if (r_ovf || (r_q[RES_W-1] && (r_q[RES_W-2:0] != '0))) begin
            w_sat = {1'b1, {(RES_W-1){1'b0}}};
        end else begin
            w_sat = RES_W'(0) - r_q;
        end
    end

    assign o_pop      = (r_state == S_IDLE) && !i_q_status.empty;
    assign w_out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_status.empty) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_half) begin
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    if (r_oi != 3'd0) begin
                        r_state <= S_CHK;
                    end else if (w_acc == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_CHK: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_bit == 5'd31) begin
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    r_state <= (r_oi == 3'(NUM_RES)) ? S_OUT : S_MUL;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job  <= i_job;
                r_half <= 1'b0;
                r_oi   <= 3'd0;
                r_deg  <= 1'b0;
            end
            S_MUL: begin
                if (r_half) begin
                    r_p1 <= PROD_W'(w_ma) * PROD_W'(w_mb);
                end else begin
                    r_p0 <= PROD_W'(w_ma) * PROD_W'(w_mb);
                end
                r_half <= !r_half;
            end
            S_SUB: begin
                if (r_oi == 3'd0) begin
                    r_det  <= w_acc[DET_W-1:0];
                    r_dmag <= w_acc[ACC_W-1] ? DET_W'(-w_acc) : DET_W'(w_acc);
                    r_oi   <= 3'd1;
                    if (w_acc == '0) begin
                        r_deg <= 1'b1;
                        for (int i = 0; i < NUM_RES; i++) begin
                            r_res[i] <= '0;
                        end
                    end
                end else begin
                    r_un  <= w_acc[ACC_W-1] ? UN_W'(-w_acc) : UN_W'(w_acc);
                    r_neg <= w_acc[ACC_W-1] ^ r_det[DET_W-1];
                end
            end
            S_CHK: begin
                // The quotient reaches 2^32 exactly when the numerator is at
                // least the divisor scaled by 2^14.
                r_ovf <= (CMP_W'(r_un) >= {r_dmag, 14'b0});
                r_rem <= DET_W'(r_un[UN_W-1:14]);
                r_dlo <= {r_un[13:0], 18'b0};
                r_q   <= '0;
                r_bit <= 5'd0;
            end
            S_DIV: begin
                r_rem <= w_ge ? DET_W'(w_r2 - {1'b0, r_dmag}) : DET_W'(w_r2);
                r_q   <= {r_q[RES_W-2:0], w_ge};
                r_dlo <= {r_dlo[RES_W-2:0], 1'b0};
                r_bit <= r_bit + 5'd1;
            end
            S_SAT: begin
                r_res[w_ridx] <= w_sat;
                r_oi          <= r_oi + 3'd1;
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out  <= r_res;
                    r_odeg <= r_deg;
                end
            end
            default: begin
                r_half <= 1'b0;
            end
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_tan_s_x    = r_out[0];
    assign o_tan_s_y    = r_out[1];
    assign o_tan_s_z    = r_out[2];
    assign o_tan_t_x    = r_out[3];
    assign o_tan_t_y    = r_out[4];
    assign o_tan_t_z    = r_out[5];
    assign o_degenerate = r_odeg;

endmodule

/* dv/triangle_tangent_basis_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle tangent basis testbench
// Sends vertex transfers with random gaps while the result side stalls at
// random. Each third vertex is run through an in-bench model of the tangent
// math, and every tangent transfer is checked field by field against it.
// ----------------------------------------------------------------------------
module triangle_tangent_basis_tb;
    import ttb_pkg::*;

    // One vertex as the driver sends it.
    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic signed [TEX_W-1:0] tu;
        logic signed [TEX_W-1:0] tv;
    } t_vertex;

    // One tangent result, with the degenerate flag in the low bit.
    typedef struct packed {
        logic signed [RES_W-1:0] sx;
        logic signed [RES_W-1:0] sy;
        logic signed [RES_W-1:0] sz;
        logic signed [RES_W-1:0] tx;
        logic signed [RES_W-1:0] ty;
        logic signed [RES_W-1:0] tz;
        logic                    degen;
    } t_tangent;

    localparam int NUM_TRIANGLES = 400;
    // The limit lies well above a triangle's time in the block plus the longest
    // result-side stall, so reaching it without a transfer means something is stuck.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 300;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [POS_W-1:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [TEX_W-1:0] i_tex_u, i_tex_v;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [RES_W-1:0] o_tan_s_x, o_tan_s_y, o_tan_s_z;
    logic signed [RES_W-1:0] o_tan_t_x, o_tan_t_y, o_tan_t_z;
    logic                    o_degenerate;

    triangle_tangent_basis DUT (.*);

    t_vertex  vertex_queue[$];
    t_tangent tangent_expected[$];

    // Copy of the triangle state for prediction.
    t_vertex  held_vertex[2];
    int       vertex_seen;

    int  mismatch_count;
    int  tangents_checked;
    int  degenerate_seen;
    int  saturated_seen;
    int  watchdog;
    bit  stimulus_done;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // num * 2^18 / den, truncated toward zero, then clamped to 32 bits.
    function automatic logic signed [RES_W-1:0] scaled_quotient(longint num, longint den);
        longint q;
        logic   neg;
        neg = (num < 0) != (den < 0);
        if (num < 0) num = -num;
        if (den < 0) den = -den;
        // Numerators stay below 2^45, so the shift cannot overflow 64 bits.
        q = (num <<< 18) / den;
        if (!neg) begin
            if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
            return q[RES_W-1:0];
        end
        if (q > 64'sh80000000) q = 64'sh80000000;
        q = -q;
        return q[RES_W-1:0];
    endfunction

    // Takes one accepted vertex; on the third of a triangle, queues the tangents.
    task automatic predict_tangents(input t_vertex v);
        longint   x1, y1, z1, x2, y2, z2, s1, t1, s2, t2, det;
        t_tangent r;
        if (vertex_seen < 2) begin
            held_vertex[vertex_seen] = v;
            vertex_seen++;
        end else begin
            vertex_seen = 0;
            x1 = longint'(held_vertex[1].px) - longint'(held_vertex[0].px);
            y1 = longint'(held_vertex[1].py) - longint'(held_vertex[0].py);
            z1 = longint'(held_vertex[1].pz) - longint'(held_vertex[0].pz);
            x2 = longint'(v.px) - longint'(held_vertex[0].px);
            y2 = longint'(v.py) - longint'(held_vertex[0].py);
            z2 = longint'(v.pz) - longint'(held_vertex[0].pz);
            s1 = longint'(held_vertex[1].tu) - longint'(held_vertex[0].tu);
            t1 = longint'(held_vertex[1].tv) - longint'(held_vertex[0].tv);
            s2 = longint'(v.tu) - longint'(held_vertex[0].tu);
            t2 = longint'(v.tv) - longint'(held_vertex[0].tv);
            det = s1 * t2 - s2 * t1;
            r = '0;
            if (det == 0) begin
                r.degen = 1'b1;
            end else begin
                r.sx = scaled_quotient(t2 * x1 - t1 * x2, det);
                r.sy = scaled_quotient(t2 * y1 - t1 * y2, det);
                r.sz = scaled_quotient(t2 * z1 - t1 * z2, det);
                r.tx = scaled_quotient(s1 * x2 - s2 * x1, det);
                r.ty = scaled_quotient(s1 * y2 - s2 * y1, det);
                r.tz = scaled_quotient(s1 * z2 - s2 * z1, det);
            end
            tangent_expected = {tangent_expected, r};
        end
    endtask

    function automatic t_vertex random_vertex(int spread);
        t_vertex v;
        v.px = POS_W'($urandom); v.py = POS_W'($urandom); v.pz = POS_W'($urandom);
        v.tu = TEX_W'($urandom); v.tv = TEX_W'($urandom);
        // Small spreads narrow only x, u and v; wide ones leave all fields random to drive saturation.
        if (spread == 0) begin
            v.px = POS_W'($urandom_range(0, 8191)) - POS_W'(4096);
            v.tu = TEX_W'($urandom_range(0, 2047)) - TEX_W'(1024);
            v.tv = TEX_W'($urandom_range(0, 2047)) - TEX_W'(1024);
        end
        return v;
    endfunction

    // Directed triangles, then random ones. Each vertex holds five fields, and
    // kinds 0 to 5 of the ten random kinds draw their vertices with the small spread.
    initial begin
        t_vertex a, b, c;
        int      kind;
        a = '0; b = '0; c = '0;
        // Unit triangle: u along x, v along y.
        b.px = 24'sd4096; b.tu = 18'sd16384;
        c.py = 24'sd4096; c.tv = 18'sd16384;
        vertex_queue = {vertex_queue, a, b, c};
        // Zero determinant: the third vertex repeats the first.
        vertex_queue = {vertex_queue, a, b, a};
        // Collinear texture coordinates with nonzero deltas.
        c = b; c.tu = 18'sd8192; c.py = 24'sd100;
        vertex_queue = {vertex_queue, a, b, c};
        // Field extremes with the smallest determinant: saturates both ways.
        a = '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 18'sh20000, 18'sh20000};
        b = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 18'sh20001, 18'sh20000};
        c = '{24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 18'sh20000, 18'sh20001};
        vertex_queue = {vertex_queue, a, b, c};
        // Largest texture deltas.
        a = '{24'sh7FFFFF, 24'sh000000, 24'sh800000, 18'sh1FFFF, 18'sh20000};
        b = '{24'sh800000, 24'sh7FFFFF, 24'sh000000, 18'sh20000, 18'sh1FFFF};
        c = '{24'sh000000, 24'sh800000, 24'sh7FFFFF, 18'sh1FFFF, 18'sh1FFFF};
        vertex_queue = {vertex_queue, a, b, c};
        // Negative determinant.
        a = '0; b = '0; c = '0;
        b.px = 24'sd4096; b.tv = 18'sd16384; c.py = 24'sd4096; c.tu = 18'sd16384;
        vertex_queue = {vertex_queue, a, b, c};
        for (int t = 0; t < NUM_TRIANGLES; t++) begin
            kind = $urandom_range(0, 9);
            a = random_vertex(kind < 6 ? 0 : 1);
            b = random_vertex(kind < 6 ? 0 : 1);
            c = random_vertex(kind < 6 ? 0 : 1);
            // A share of degenerate triangles with otherwise random content.
            if (kind == 9) begin
                b.tu = a.tu; c.tu = a.tu;
            end
            vertex_queue = {vertex_queue, a, b, c};
        end
    end

    // Driver: one vertex per transfer, each after a random gap, which may be zero.
    int send_gap;
    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= $urandom_range(0, 14);
        end else if (i_valid && !o_stall) begin
            predict_tangents('{i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v});
            gap = $urandom_range(0, 14);
            if (vertex_queue.size() == 0) begin
                i_valid       <= 1'b0;
                stimulus_done <= 1'b1;
            end else if (gap == 0) begin
                // No gap: the next vertex follows at once and valid stays high.
                {i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v} <= vertex_queue.pop_front();
            end else begin
                i_valid  <= 1'b0;
                send_gap <= gap - 1;
            end
        end else if (!i_valid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (vertex_queue.size() != 0) begin
                {i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v} <= vertex_queue.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    // Monitor and result-side stalls: after each transfer a stall length is
    // drawn, and it counts only the cycles in which a result is waiting.
    int stall_left;
    always @(posedge i_clk) begin
        t_tangent seen, want;
        int       stall_draw;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && !i_stall) begin
            seen = '{o_tan_s_x, o_tan_s_y, o_tan_s_z,
                     o_tan_t_x, o_tan_t_y, o_tan_t_z, o_degenerate};
            tangents_checked++;
            if (tangent_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected tangent transfer: %p", seen);
            end else begin
                want = tangent_expected.pop_front();
                if (want.degen) degenerate_seen++;
                if (want.sx == 32'sh7FFFFFFF || want.sx == 32'sh80000000)
                    saturated_seen++;
                if (seen !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("tangent mismatch: expected %p, got %p", want, seen);
                end
            end
            stall_draw = $urandom_range(0, 14);
            stall_left <= stall_draw;
            i_stall    <= (stall_draw != 0);
        end else if (o_valid && i_stall) begin
            stall_left <= stall_left - 1;
            i_stall    <= (stall_left > 1);
        end
    end

    // Watchdog on the absence of any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d tangents outstanding",
                     tangent_expected.size());
            $display("triangle_tangent_basis_tb: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        {i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v} = '0;
        vertex_seen = 0;
        mismatch_count = 0;
        tangents_checked = 0;
        degenerate_seen = 0;
        saturated_seen = 0;
        watchdog = 0;
        stimulus_done = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && tangent_expected.size() == 0);
        // Give a stray extra result time to appear.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("checked %0d triangles, %0d degenerate, %0d with saturated s.x",
                 tangents_checked, degenerate_seen, saturated_seen);
        if (mismatch_count == 0 && tangent_expected.size() == 0) begin
            $display("triangle_tangent_basis_tb: clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("triangle_tangent_basis_tb: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/ttb_pkg.sv
hdl/ttb_front.sv
hdl/ttb_queue.sv
hdl/ttb_back.sv
hdl/triangle_tangent_basis.sv
dv/triangle_tangent_basis_tb.sv
